>>> design/world_to_screen_projection_unit_macros.svh
// Assertion macros used by the projection unit top module.
`ifndef WORLD_TO_SCREEN_PROJECTION_UNIT_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTION_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define W2S_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the next cycle, outside reset.
`define W2S_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/w2s_pkg.sv
// ----------------------------------------------------------------------------
// w2s_pkg
// Shared types and constants of the world-to-screen projection unit.
// ----------------------------------------------------------------------------
package w2s_pkg;

   localparam int unsigned CSR_WIDTH = 64;
   localparam int unsigned CSR_COUNT = 8;
   localparam int unsigned CSR_IDX_WIDTH = 3;
   localparam int unsigned DATA_WIDTH = 32;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_COL_X_FIRST  = 3'd0,
      CSR_COL_X_SECOND = 3'd1,
      CSR_COL_Y_FIRST  = 3'd2,
      CSR_COL_Y_SECOND = 3'd3,
      CSR_COL_W_FIRST  = 3'd4,
      CSR_COL_W_SECOND = 3'd5,
      CSR_VP_ORIGIN    = 3'd6,
      CSR_VP_SIZE      = 3'd7
   } csr_index_type;

   localparam logic [CSR_WIDTH-1:0] COL_W_SECOND_RESET = 64'd65536;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] world_x;
      logic signed [DATA_WIDTH-1:0] world_y;
      logic signed [DATA_WIDTH-1:0] world_z;
   } req_payload_type;

   typedef struct packed {
      logic                         visible;
      logic signed [DATA_WIDTH-1:0] pixel_x;
      logic signed [DATA_WIDTH-1:0] pixel_y;
   } rsp_payload_type;

   // One matrix column as used by the dot product.
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] mx;
      logic signed [DATA_WIDTH-1:0] my;
      logic signed [DATA_WIDTH-1:0] mz;
      logic signed [DATA_WIDTH-1:0] mt;
   } column_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] org_x;
      logic signed [DATA_WIDTH-1:0] org_y;
      logic signed [DATA_WIDTH-1:0] size_w;
      logic signed [DATA_WIDTH-1:0] size_h;
   } viewport_type;

endpackage

>>> design/world_to_screen_projection_unit.sv
// ----------------------------------------------------------------------------
// world_to_screen_projection_unit
// Projects world points to viewport pixels through a configured matrix.
// ----------------------------------------------------------------------------
// One request may be issued every clock; busy is always low. Each request
// yields exactly one response after it passes the registered matrix products
// and sum, the pipelined divider (magnitudes, an overflow check, one stage per
// quotient bit and the sign) and the registered viewport map. The receiver
// cannot stall; responses appear in request order with rsp_valid high for one
// cycle.
module world_to_screen_projection_unit #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  w2s_pkg::req_payload_type          req_payload,
   output logic                              rsp_valid,
   output w2s_pkg::rsp_payload_type          rsp_payload,
   input  logic                              csr_write,
   input  logic [w2s_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [w2s_pkg::CSR_WIDTH-1:0]     csr_wdata
);
   import w2s_pkg::*;
   `include "world_to_screen_projection_unit_macros.svh"

   localparam int unsigned CW = 2 * DATA_WIDTH - FRAC_BITS + 2;
   localparam int unsigned DIV_LAT = DATA_WIDTH + 2;
   localparam int unsigned LAT = 2 + DIV_LAT + 2;
   localparam int unsigned MW = DATA_WIDTH + 2;

   column_type   col_x, col_y, col_w;
   viewport_type viewport;
   logic signed [CW-1:0] clip_x, clip_y, clip_w;
   logic signed [DATA_WIDTH-1:0] ndc_x, ndc_y;
   logic [LAT-1:0] valid_ff;
   logic [DIV_LAT-1:0] vis_ff;
   logic signed [2*MW-1:0] map_x_ff, map_y_ff;
   logic vis_map_ff;
   rsp_payload_type rsp_ff;
   logic signed [2*MW+1:0] px_in, py_in;

   function automatic logic signed [DATA_WIDTH-1:0] sat(
      input logic signed [2*MW+1:0] v);
      logic signed [2*MW+1:0] hi;
      logic signed [2*MW+1:0] lo;
      hi = (2*MW+2)'({1'b0, {(DATA_WIDTH-1){1'b1}}});
      lo = -hi - 1;
      if (v > hi) begin
         return hi[DATA_WIDTH-1:0];
      end else if (v < lo) begin
         return lo[DATA_WIDTH-1:0];
      end
      return v[DATA_WIDTH-1:0];
   endfunction

   w2s_csr u_csr (
      .clock, .reset, .csr_write, .csr_index, .csr_wdata,
      .col_x, .col_y, .col_w, .viewport
   );

   w2s_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_x (.clock,
      .px(req_payload.world_x), .py(req_payload.world_y),
      .pz(req_payload.world_z), .col(col_x), .clip(clip_x));
   w2s_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_y (.clock,
      .px(req_payload.world_x), .py(req_payload.world_y),
      .pz(req_payload.world_z), .col(col_y), .clip(clip_y));
   w2s_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_w (.clock,
      .px(req_payload.world_x), .py(req_payload.world_y),
      .pz(req_payload.world_z), .col(col_w), .clip(clip_w));

   // A non-positive w is replaced by one so the divider stays defined.
   logic signed [CW-1:0] den;
   assign den = (clip_w > 0) ? clip_w : CW'(1);

   w2s_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (.clock, .num(clip_x), .den(den),
      .quot(ndc_x));
   w2s_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (.clock, .num(clip_y), .den(den),
      .quot(ndc_y));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[LAT-2:0], start};
      end
   end

   always_ff @(posedge clock) begin
      vis_ff     <= {vis_ff[DIV_LAT-2:0], clip_w > 0};
      map_x_ff   <= (MW'(ndc_x) + MW'(signed'(CW'(1) <<< FRAC_BITS)))
                    * MW'(viewport.size_w);
      map_y_ff   <= (MW'(signed'(CW'(1) <<< FRAC_BITS)) - MW'(ndc_y))
                    * MW'(viewport.size_h);
      vis_map_ff <= vis_ff[DIV_LAT-1];
      rsp_ff     <= {vis_map_ff,
                     vis_map_ff ? sat(px_in) : DATA_WIDTH'(0),
                     vis_map_ff ? sat(py_in) : DATA_WIDTH'(0)};
   end

   always_comb begin
      px_in = (2*MW+2)'(viewport.org_x) + (2*MW+2)'(map_x_ff >>> (FRAC_BITS + 1));
      py_in = (2*MW+2)'(viewport.org_y) + (2*MW+2)'(map_y_ff >>> (FRAC_BITS + 1));
   end

   assign busy        = 1'b0;
   assign rsp_valid   = valid_ff[LAT-1];
   assign rsp_payload = rsp_ff;

   `W2S_ASSERT_IMPLY(a_busy_low, clock, reset, 1'b1, !busy, "busy must stay low")
   `W2S_ASSERT_IMPLY(a_invisible_zero, clock, reset, rsp_valid && !rsp_payload.visible,
      rsp_payload.pixel_x == 0 && rsp_payload.pixel_y == 0, "hidden point with pixel")
   `W2S_ASSERT_NEXT(a_pipe_shift, clock, reset, start, valid_ff[0], "request lost")

endmodule

>>> design/w2s_csr.sv
// ----------------------------------------------------------------------------
// w2s_csr
// Configuration register file; presents matrix columns and viewport.
// ----------------------------------------------------------------------------
module w2s_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [w2s_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [w2s_pkg::CSR_WIDTH-1:0]  csr_wdata,
   output w2s_pkg::column_type            col_x,
   output w2s_pkg::column_type            col_y,
   output w2s_pkg::column_type            col_w,
   output w2s_pkg::viewport_type          viewport
);
   import w2s_pkg::*;

   logic [CSR_WIDTH-1:0] regs_ff [CSR_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CSR_COUNT; i++) begin
            regs_ff[i] <= '0;
         end
         regs_ff[CSR_COL_W_SECOND] <= COL_W_SECOND_RESET;
      end else if (csr_write) begin
         regs_ff[csr_index] <= csr_wdata;
      end
   end

   assign col_x = {regs_ff[CSR_COL_X_FIRST], regs_ff[CSR_COL_X_SECOND]};
   assign col_y = {regs_ff[CSR_COL_Y_FIRST], regs_ff[CSR_COL_Y_SECOND]};
   assign col_w = {regs_ff[CSR_COL_W_FIRST], regs_ff[CSR_COL_W_SECOND]};
   assign viewport = {regs_ff[CSR_VP_ORIGIN], regs_ff[CSR_VP_SIZE]};

endmodule

>>> design/w2s_dot.sv
// ----------------------------------------------------------------------------
// w2s_dot
// Two-stage dot product of the point with one matrix column.
// ----------------------------------------------------------------------------
module w2s_dot #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic signed [w2s_pkg::DATA_WIDTH-1:0] px,
   input  logic signed [w2s_pkg::DATA_WIDTH-1:0] py,
   input  logic signed [w2s_pkg::DATA_WIDTH-1:0] pz,
   input  w2s_pkg::column_type               col,
   output logic signed [2*w2s_pkg::DATA_WIDTH-FRAC_BITS+1:0] clip
);
   import w2s_pkg::*;

   localparam int unsigned PW = 2 * DATA_WIDTH;
   localparam int unsigned SW = PW - FRAC_BITS;

   logic signed [PW-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [DATA_WIDTH-1:0] trans_ff;
   logic signed [SW+1:0] clip_ff;
   logic signed [SW+1:0] sum_in;

   always_ff @(posedge clock) begin
      prod_x_ff <= px * col.mx;
      prod_y_ff <= py * col.my;
      prod_z_ff <= pz * col.mz;
      trans_ff  <= col.mt;
      clip_ff   <= sum_in;
   end

   // Arithmetic shift floors each product before the sum.
   always_comb begin
      sum_in = (SW+2)'(prod_x_ff >>> FRAC_BITS) + (SW+2)'(prod_y_ff >>> FRAC_BITS)
             + (SW+2)'(prod_z_ff >>> FRAC_BITS) + (SW+2)'(trans_ff);
   end

   assign clip = clip_ff;

endmodule

>>> design/w2s_div.sv
// ----------------------------------------------------------------------------
// w2s_div
// Pipelined restoring divider: |num| / den, signed as num, with FRAC_BITS fraction bits,
// one quotient bit per stage, saturated to the 32-bit signed range.
// ----------------------------------------------------------------------------
module w2s_div #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic signed [2*w2s_pkg::DATA_WIDTH-FRAC_BITS+1:0] num,
   input  logic signed [2*w2s_pkg::DATA_WIDTH-FRAC_BITS+1:0] den,
   output logic signed [w2s_pkg::DATA_WIDTH-1:0] quot
);
   import w2s_pkg::*;

   localparam int unsigned NW = 2 * DATA_WIDTH - FRAC_BITS + 2;
   localparam int unsigned QB = DATA_WIDTH - 1;
   localparam int unsigned LB = QB - FRAC_BITS;

   logic [NW-1:0] mag_ff;
   logic [NW-1:0] den0_ff;
   logic          neg0_ff;
   logic [NW-1:0] rem_ff [QB];
   logic [NW-1:0] den_ff [QB];
   logic [QB-1:0] low_ff [QB];
   logic [QB-1:0] q_ff   [QB+1];
   logic          neg_ff [QB+1];
   logic          sat_ff [QB+1];
   logic signed [DATA_WIDTH-1:0] quot_ff;

   always_ff @(posedge clock) begin
      mag_ff  <= num[NW-1] ? NW'(-num) : NW'(num);
      den0_ff <= NW'(den);
      neg0_ff <= num[NW-1];
   end

   // The scaled dividend is mag * 2^FRAC_BITS. Its bits above the QB quotient
   // positions form the first remainder; a quotient of 2^QB or more saturates.
   always_ff @(posedge clock) begin
      rem_ff[0] <= mag_ff >> LB;
      den_ff[0] <= den0_ff;
      low_ff[0] <= {mag_ff[LB-1:0], {FRAC_BITS{1'b0}}};
      q_ff[0]   <= '0;
      neg_ff[0] <= neg0_ff;
      sat_ff[0] <= (mag_ff >> LB) >= den0_ff;
   end

   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic [NW:0] trial;
      logic [NW:0] diff;
      always_comb begin
         trial = {rem_ff[k], low_ff[k][QB-1]};
         diff  = trial - {1'b0, den_ff[k]};
      end
      always_ff @(posedge clock) begin
         q_ff[k+1]   <= {q_ff[k][QB-2:0], !diff[NW]};
         neg_ff[k+1] <= neg_ff[k];
         sat_ff[k+1] <= sat_ff[k];
      end
      if (k + 1 < QB) begin : g_next
         always_ff @(posedge clock) begin
            rem_ff[k+1] <= diff[NW] ? trial[NW-1:0] : diff[NW-1:0];
            den_ff[k+1] <= den_ff[k];
            low_ff[k+1] <= low_ff[k] << 1;
         end
      end
   end

   // Saturated magnitude is 2^31: +2^31 clips to max, -2^31 stays.
   always_ff @(posedge clock) begin
      if (sat_ff[QB]) begin
         quot_ff <= neg_ff[QB] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                               : {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end else begin
         quot_ff <= neg_ff[QB] ? -DATA_WIDTH'(q_ff[QB]) : DATA_WIDTH'(q_ff[QB]);
      end
   end

   assign quot = quot_ff;

endmodule

>>> tb/sv/world_to_screen_projection_unit_test.sv
// ----------------------------------------------------------------------------
// world_to_screen_projection_unit_test
// Drives world points through several matrix and viewport settings and
// checks every projected pixel against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module world_to_screen_projection_unit_test;
   import w2s_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam int LATENCY = 2 + FRAC + 18 + 2;
   localparam int CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   rsp_payload_type rsp_payload;
   logic csr_write = 1'b0;
   logic [CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic [CSR_WIDTH-1:0] csr_wdata = '0;

   req_payload_type point_q[$];
   rsp_payload_type pixel_q[$];
   logic [CSR_WIDTH-1:0] csr_shadow [CSR_COUNT];
   int errors = 0;
   int cycles = 0;
   int idle_left = 0;
   bit idle_on = 1'b1;

   world_to_screen_projection_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint hi_of(logic [63:0] v);
      return longint'($signed(v[63:32]));
   endfunction

   function automatic longint lo_of(logic [63:0] v);
      return longint'($signed(v[31:0]));
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint column_dot(longint x, longint y, longint z,
                                         logic [63:0] first, logic [63:0] second);
      longint acc;
      acc = (x * hi_of(first)) >>> FRAC;
      acc += (y * lo_of(first)) >>> FRAC;
      acc += (z * hi_of(second)) >>> FRAC;
      acc += lo_of(second);
      return acc;
   endfunction

   // Restoring division, truncated toward zero; den is known positive.
   function automatic longint ndc_divide(longint num, longint den);
      bit neg;
      longint unsigned a, w, q, r, mag;
      neg = num < 0;
      a = neg ? -num : num;
      w = den;
      q = a / w;
      r = a % w;
      if (q >= (64'd1 << (31 - FRAC))) begin
         mag = 64'd1 << 31;
      end else begin
         mag = q << FRAC;
         for (int i = FRAC - 1; i >= 0; i--) begin
            r = r << 1;
            if (r >= w) begin
               r -= w;
               mag |= 64'd1 << i;
            end
         end
      end
      return clamp32(neg ? -longint'(mag) : longint'(mag));
   endfunction

   function automatic rsp_payload_type project_point(req_payload_type p);
      longint x, y, z, cx, cy, cw, nx, ny, px, py;
      longint one;
      rsp_payload_type r;
      one = 64'sd1 << FRAC;
      x = longint'(p.world_x);
      y = longint'(p.world_y);
      z = longint'(p.world_z);
      cx = column_dot(x, y, z, csr_shadow[CSR_COL_X_FIRST], csr_shadow[CSR_COL_X_SECOND]);
      cy = column_dot(x, y, z, csr_shadow[CSR_COL_Y_FIRST], csr_shadow[CSR_COL_Y_SECOND]);
      cw = column_dot(x, y, z, csr_shadow[CSR_COL_W_FIRST], csr_shadow[CSR_COL_W_SECOND]);
      r = '0;
      if (cw <= 0) return r;
      nx = ndc_divide(cx, cw);
      ny = ndc_divide(cy, cw);
      px = hi_of(csr_shadow[CSR_VP_ORIGIN])
         + (((nx + one) * hi_of(csr_shadow[CSR_VP_SIZE])) >>> (FRAC + 1));
      py = lo_of(csr_shadow[CSR_VP_ORIGIN])
         + (((one - ny) * lo_of(csr_shadow[CSR_VP_SIZE])) >>> (FRAC + 1));
      r.visible = 1'b1;
      r.pixel_x = 32'(clamp32(px));
      r.pixel_y = 32'(clamp32(py));
      return r;
   endfunction

   // Driver: the head of the queue stays on the port until it is accepted.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (idle_left > 0) begin
         idle_left <= idle_left - 1;
         start <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         idle_left <= $urandom_range(1, 12) - 1;
         start <= 1'b0;
      end else if (point_q.size() > 0) begin
         start <= 1'b1;
         req_payload <= point_q[0];
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: predicts on acceptance and checks each response.
   always @(posedge clock) begin
      rsp_payload_type want;
      cycles <= cycles + 1;
      if (!reset) begin
         if (start && !busy) begin
            pixel_q.push_back(project_point(req_payload));
            void'(point_q.pop_front());
         end
         if (rsp_valid) begin
            if (pixel_q.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_payload);
               errors++;
            end else begin
               want = pixel_q.pop_front();
               if (rsp_payload.visible !== want.visible) begin
                  $display("%0t: visible expected %0d actual %0d",
                           $time, want.visible, rsp_payload.visible);
                  errors++;
               end
               if (rsp_payload.pixel_x !== want.pixel_x) begin
                  $display("%0t: pixel_x expected %h actual %h",
                           $time, want.pixel_x, rsp_payload.pixel_x);
                  errors++;
               end
               if (rsp_payload.pixel_y !== want.pixel_y) begin
                  $display("%0t: pixel_y expected %h actual %h",
                           $time, want.pixel_y, rsp_payload.pixel_y);
                  errors++;
               end
            end
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [63:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      csr_shadow[idx] = data;
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic drain();
      while (point_q.size() > 0 || pixel_q.size() > 0) @(posedge clock);
   endtask

   function automatic logic [31:0] coord(bit wide);
      if (wide) return $urandom();
      return $unsigned(32'($signed($urandom_range(0, 2 * 6553600)) - 6553600));
   endfunction

   task automatic add_points(int n);
      req_payload_type p;
      repeat (n) begin
         p.world_x = coord($urandom_range(0, 3) == 0);
         p.world_y = coord($urandom_range(0, 3) == 0);
         p.world_z = coord($urandom_range(0, 3) == 0);
         point_q.push_back(p);
      end
   endtask

   task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      req_payload_type p;
      p.world_x = x;
      p.world_y = y;
      p.world_z = z;
      point_q.push_back(p);
   endtask

   task automatic random_regs();
      for (int i = 0; i < CSR_COUNT; i++)
         write_reg(csr_index_type'(i), {$urandom(), $urandom()});
      end_writes();
   endtask

   initial begin
      for (int i = 0; i < CSR_COUNT; i++) csr_shadow[i] = '0;
      csr_shadow[CSR_COL_W_SECOND] = COL_W_SECOND_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset matrix: w is the constant 1.0 and the viewport is empty.
      add_point(32'h0, 32'h0, 32'h0);
      add_points(60);
      drain();

      // Simple perspective: w = -z, 1920 by 1080 viewport.
      write_reg(CSR_COL_X_FIRST, {32'h0001_0000, 32'h0});
      write_reg(CSR_COL_X_SECOND, 64'h0);
      write_reg(CSR_COL_Y_FIRST, {32'h0, 32'h0001_0000});
      write_reg(CSR_COL_Y_SECOND, 64'h0);
      write_reg(CSR_COL_W_FIRST, 64'h0);
      write_reg(CSR_COL_W_SECOND, {32'hFFFF_0000, 32'h0});
      write_reg(CSR_VP_ORIGIN, {32'h0000_8000, 32'hFFFF_8000});
      write_reg(CSR_VP_SIZE, {32'd1920 << 16, 32'd1080 << 16});
      end_writes();
      add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);   // tiny w, huge ndc
      add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      add_point(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
      add_point(32'h0, 32'h0, 32'h0);                          // w exactly zero
      add_point(32'h0001_0000, 32'h0, 32'h0001_0000);          // behind the eye
      add_point(32'h0, 32'h0, 32'h7FFF_FFFF);
      add_point(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE);
      add_point(32'h0, 32'h0, 32'hFFFF_FFFF);
      add_point(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFE_0000);
      add_points(160);
      drain();

      // Extremes of the matrix entries, but for the w translation, and a maximal viewport.
      write_reg(CSR_COL_X_FIRST, {32'h7FFF_FFFF, 32'h8000_0000});
      write_reg(CSR_COL_X_SECOND, {32'h8000_0000, 32'h7FFF_FFFF});
      write_reg(CSR_COL_Y_FIRST, {32'h8000_0000, 32'h8000_0000});
      write_reg(CSR_COL_Y_SECOND, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
      write_reg(CSR_COL_W_FIRST, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
      write_reg(CSR_COL_W_SECOND, {32'h7FFF_FFFF, 32'h0000_0001});
      write_reg(CSR_VP_ORIGIN, {32'h7FFF_FFFF, 32'h8000_0000});
      write_reg(CSR_VP_SIZE, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
      end_writes();
      add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_point(32'h0, 32'h0, 32'h0);
      add_points(140);
      drain();

      // Degenerate viewport: negative width, zero height; w gets z weight -0.5 and offset 2.0.
      write_reg(CSR_VP_ORIGIN, 64'h0);
      write_reg(CSR_VP_SIZE, {32'h8000_0000, 32'h0});
      write_reg(CSR_COL_W_SECOND, {32'hFFFF_8000, 32'h0002_0000});
      end_writes();
      add_points(140);
      drain();

      random_regs();
      add_points(140);
      drain();

      idle_on = 1'b0;
      random_regs();
      add_points(140);
      drain();

      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
